// ===== hdl/pcru_pkg.sv =====
package pcru_pkg;

  // Chain and buffer sizing
  localparam int CHAIN_MODULES = 2;
  localparam int STORE_DEPTH   = 18;
  localparam int BCNT_W        = 5;
  localparam int MOD_W         = 4;
  localparam int VIDX_W        = 4;
  localparam int VALUE_W       = 14;
  localparam int MASK_W        = 12;
  localparam int RAW_W         = 12;

  // PEC and conversion constants
  localparam logic [7:0]  CRC_START  = 8'h41;
  localparam logic [7:0]  CRC_POLY   = 8'h07;
  localparam logic [12:0] RAW_OFFSET = 13'd512;

  // Last result index per module for the multi-result groups
  localparam logic [VIDX_W-1:0] CELL_LAST_IDX = 4'd11;
  localparam logic [VIDX_W-1:0] TEMP_LAST_IDX = 4'd2;

  // Job queue between the byte front end and the unpacker
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic [1:0] {
    GRP_CELLS = 2'd0,
    GRP_TEMPS = 2'd1,
    GRP_FLAGS = 2'd2,
    GRP_REF   = 2'd3
  } grp_t;

  typedef logic [STORE_DEPTH-1:0][7:0] store_t;

  // One checked module handed from the front end to the unpacker
  typedef struct packed {
    store_t            data;
    logic [MOD_W-1:0]  module_index;
    grp_t              grp;
    logic              pec_err;
    logic              final_mod;
  } job_t;

  // Number of data bytes that precede the PEC byte
  function automatic logic [BCNT_W-1:0] grp_len(input grp_t g);
    logic [BCNT_W-1:0] n;
    case (g)
      GRP_CELLS: n = 5'd18;
      GRP_TEMPS: n = 5'd5;
      GRP_FLAGS: n = 5'd3;
      GRP_REF:   n = 5'd2;
      default:   n = 5'd2;
    endcase
    return n;
  endfunction

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/pcru_front.sv =====
module pcru_front import pcru_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  input  grp_t       reg_group,
  output logic       push,
  output job_t       push_job,
  input  logic       q_full
);

  logic              active_r, active_nxt;
  grp_t              grp_r, grp_nxt;
  logic [BCNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [MOD_W-1:0]  module_r, module_nxt;
  logic [7:0]        crc_r, crc_nxt;
  store_t            store_r;

  logic accept;
  logic is_data;
  logic pec_ok;
  logic last_mod;

  // Beats are taken whenever the job queue has room
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign is_data  = byte_count_r < grp_len(grp_r);
  assign pec_ok   = (rx_byte == crc_r);
  assign last_mod = ({1'b0, module_r} + (MOD_W + 1)'(1)) >= (MOD_W + 1)'(CHAIN_MODULES);

  // A PEC beat of an armed frame becomes a job for the unpacker
  assign push = accept && !frame_start && active_r && !is_data;

  always_comb begin
    push_job.data         = store_r;
    push_job.module_index = module_r;
    push_job.grp          = grp_r;
    push_job.pec_err      = !pec_ok;
    push_job.final_mod    = last_mod;
  end

  // Frame tracking, byte counting and running CRC
  always_comb begin
    active_nxt     = active_r;
    grp_nxt        = grp_r;
    byte_count_nxt = byte_count_r;
    module_nxt     = module_r;
    crc_nxt        = crc_r;
    if (accept) begin
      if (frame_start) begin
        active_nxt     = 1'b1;
        grp_nxt        = reg_group;
        byte_count_nxt = '0;
        module_nxt     = '0;
        crc_nxt        = CRC_START;
      end else if (active_r) begin
        if (is_data) begin
          crc_nxt        = crc8_update(crc_r, rx_byte);
          byte_count_nxt = byte_count_r + BCNT_W'(1);
        end else if (!pec_ok) begin
          active_nxt = 1'b0;
        end else begin
          module_nxt     = module_r + MOD_W'(1);
          byte_count_nxt = '0;
          crc_nxt        = CRC_START;
          if (last_mod) begin
            active_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      grp_r        <= GRP_CELLS;
      byte_count_r <= '0;
      module_r     <= '0;
      crc_r        <= CRC_START;
    end else begin
      active_r     <= active_nxt;
      grp_r        <= grp_nxt;
      byte_count_r <= byte_count_nxt;
      module_r     <= module_nxt;
      crc_r        <= crc_nxt;
    end
  end

  // Data byte buffer of the current module
  always_ff @(posedge clk) begin
    if (accept && !frame_start && active_r && is_data) begin
      store_r[byte_count_r] <= rx_byte;
    end
  end

endmodule

// ===== hdl/pcru_queue.sv =====
module pcru_queue import pcru_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t head
);

  job_t              entries_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == QCNT_W'(QDEPTH));
  assign valid = (count_r != '0);
  assign head  = entries_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !valid |-> !pop) else $error("job popped from an empty queue");

endmodule

// ===== hdl/pcru_back.sv =====
module pcru_back import pcru_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  job_t                      q_head,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [MOD_W-1:0]          out_module_index,
  output logic [VIDX_W-1:0]         out_value_index,
  output logic signed [VALUE_W-1:0] out_value,
  output logic [MASK_W-1:0]         out_under_mask,
  output logic [MASK_W-1:0]         out_over_mask,
  output logic                      out_status,
  output logic                      out_last,
  output logic                      out_frame_end
);

  logic [VIDX_W-1:0] idx_r, idx_nxt;
  logic              valid_r;
  logic [MOD_W-1:0]  mod_r;
  logic [VIDX_W-1:0] vidx_r;
  logic [VALUE_W-1:0] value_r;
  logic [MASK_W-1:0] under_r, over_r;
  logic              status_r, last_r, frame_end_r;

  logic [VIDX_W-1:0] last_idx;
  logic              adv;
  logic              is_last;
  logic [23:0]       trip;
  logic [RAW_W-1:0]  raw;
  logic signed [12:0] diff;
  logic signed [14:0] triple;
  logic signed [14:0] triple_adj;
  logic [MASK_W-1:0] um, om;
  logic [VIDX_W-1:0] vidx_c;
  logic [VALUE_W-1:0] value_c;
  logic [MASK_W-1:0] under_c, over_c;

  // Index of the final result of the head job
  always_comb begin
    if (q_head.pec_err) begin
      last_idx = '0;
    end else begin
      case (q_head.grp)
        GRP_CELLS: last_idx = CELL_LAST_IDX;
        GRP_TEMPS: last_idx = TEMP_LAST_IDX;
        default:   last_idx = '0;
      endcase
    end
  end

  assign is_last = (idx_r == last_idx);
  assign adv     = q_valid && (!valid_r || out_ready);
  assign pop     = adv && is_last;
  assign idx_nxt = adv ? (is_last ? '0 : idx_r + VIDX_W'(1)) : idx_r;

  // Byte triple that holds a cell pair
  always_comb begin
    trip = '0;
    for (int g = 0; g < 6; g++) begin
      if (idx_r[3:1] == 3'(g)) begin
        trip = {q_head.data[3*g+2], q_head.data[3*g+1], q_head.data[3*g]};
      end
    end
  end

  // Pick the 12-bit raw reading for this result
  always_comb begin
    case (q_head.grp)
      GRP_CELLS: raw = idx_r[0] ? {trip[23:16], trip[15:12]} : {trip[11:8], trip[7:0]};
      GRP_TEMPS: begin
        case (idx_r[1:0])
          2'd0:    raw = {q_head.data[1][3:0], q_head.data[0]};
          2'd1:    raw = {q_head.data[2], q_head.data[1][7:4]};
          default: raw = {q_head.data[4][3:0], q_head.data[3]};
        endcase
      end
      default:   raw = {q_head.data[1][3:0], q_head.data[0]};
    endcase
  end

  // (raw - 512) * 3 / 2, rounded toward zero
  always_comb begin
    diff       = $signed({1'b0, raw}) - $signed(RAW_OFFSET);
    triple     = $signed({{2{diff[12]}}, diff}) + $signed({diff[12], diff, 1'b0});
    triple_adj = triple + $signed({14'd0, triple[14] & triple[0]});
  end

  // Under- and over-voltage masks from the flag bytes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        um[4*i+j] = q_head.data[i][2*j];
        om[4*i+j] = q_head.data[i][2*j+1];
      end
    end
  end

  // Result fields by job kind
  always_comb begin
    vidx_c  = '0;
    value_c = '0;
    under_c = '0;
    over_c  = '0;
    if (!q_head.pec_err) begin
      if (q_head.grp == GRP_FLAGS) begin
        under_c = um;
        over_c  = om;
      end else begin
        vidx_c  = idx_r;
        value_c = triple_adj[14:1];
      end
    end
  end

  // Result counter and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (adv) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mod_r       <= q_head.module_index;
      vidx_r      <= vidx_c;
      value_r     <= value_c;
      under_r     <= under_c;
      over_r      <= over_c;
      status_r    <= q_head.pec_err;
      last_r      <= is_last;
      frame_end_r <= is_last && (q_head.pec_err || q_head.final_mod);
    end
  end

  assign out_valid        = valid_r;
  assign out_module_index = mod_r;
  assign out_value_index  = vidx_r;
  assign out_value        = $signed(value_r);
  assign out_under_mask   = under_r;
  assign out_over_mask    = over_r;
  assign out_status       = status_r;
  assign out_last         = last_r;
  assign out_frame_end    = frame_end_r;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= CELL_LAST_IDX) else $error("result index beyond the cell count");

  a_mid_job_head: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != '0 |-> q_valid) else $error("job left the queue before its last result");

  a_error_closes: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && status_r |-> last_r && frame_end_r)
    else $error("PEC error beat does not close the frame");

endmodule

// ===== hdl/pec_checked_readback_unpacker_core.sv =====
// Unpacks the response bytes of a daisy-chained battery-monitor register readback. A beat with
// frame_start set arms a frame and selects the register group; every later beat is one response
// byte. Data bytes of each module are buffered and checked with CRC-8 (poly 0x07, seed 0x41);
// on the PEC beat the module is handed to the unpacker through a two-entry job queue. The input
// takes one byte per cycle and stalls only while that queue is full. The unpacker emits one
// result beat per cycle while the receiver takes them: 12 for cells, 3 for temperatures, 1 for
// flags, reference or a PEC error; the output register lets a new result load in the same
// cycle the previous one is taken.
module pec_checked_readback_unpacker_core import pcru_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [2:0]  in_tuser,   // [0] frame_start, [2:1] reg_group
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [3:0] module_index, [7:4] value_index, [21:8] value,
                                  // [33:22] under_mask, [45:34] over_mask, [47:46] zero
  output logic [1:0]  out_tuser,  // [0] status, [1] frame_end
  output logic        out_tlast
);

  logic push, q_full, pop, q_valid;
  job_t push_job, q_head;

  logic [MOD_W-1:0]          r_module_index;
  logic [VIDX_W-1:0]         r_value_index;
  logic signed [VALUE_W-1:0] r_value;
  logic [MASK_W-1:0]         r_under_mask, r_over_mask;
  logic                      r_status, r_frame_end;

  // Byte intake, CRC check and module buffering
  pcru_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .rx_byte     (in_tdata),
    .frame_start (in_tuser[0]),
    .reg_group   (grp_t'(in_tuser[2:1])),
    .push        (push),
    .push_job    (push_job),
    .q_full      (q_full)
  );

  // Checked modules waiting to be unpacked
  pcru_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // Result generation
  pcru_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .pop              (pop),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_module_index (r_module_index),
    .out_value_index  (r_value_index),
    .out_value        (r_value),
    .out_under_mask   (r_under_mask),
    .out_over_mask    (r_over_mask),
    .out_status       (r_status),
    .out_last         (out_tlast),
    .out_frame_end    (r_frame_end)
  );

  // Output beat packing
  assign out_tdata = {2'b00, r_over_mask, r_under_mask, r_value, r_value_index, r_module_index};
  assign out_tuser = {r_frame_end, r_status};

endmodule

// ===== dv/tb_pec_checked_readback_unpacker_core.sv =====
`timescale 1ns / 100ps

module tb_pec_checked_readback_unpacker_core;
  import pcru_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BEATS = 250;
  localparam int TAIL_CYCLES = 40;

  // How the PEC byte of a stimulus row is formed
  typedef enum logic [1:0] {
    PEC_NONE = 2'd0,
    PEC_GOOD = 2'd1,
    PEC_BAD  = 2'd2
  } pec_t;

  // One unpacked reading as it leaves the block
  typedef struct packed {
    logic [MOD_W-1:0]   mod;
    logic [VIDX_W-1:0]  vidx;
    logic [VALUE_W-1:0] value;
    logic [MASK_W-1:0]  under;
    logic [MASK_W-1:0]  over;
    logic               status;
    logic               last;
    logic               fend;
  } reading_t;

  // One row of the directed stimulus table
  typedef struct packed {
    logic     start;
    grp_t     grp;
    logic [7:0] rx;
    pec_t     pec;
    logic     typed;
    reading_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic [2:0]  in_tuser = 3'b000;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int cycles = 0;
  int mismatch_count = 0;
  int results_seen = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  // Predictor state, a copy of what the block holds
  logic [7:0]        chain_bytes [STORE_DEPTH];
  logic [BCNT_W-1:0] bytes_in;
  logic [MOD_W-1:0]  modules_done;
  logic [7:0]        pec_now;
  logic              frame_armed;
  grp_t              grp_held;

  reading_t readings_due[$];
  reading_t new_readings[$];

  pec_checked_readback_unpacker_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #CLK_HALF clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d readings still due", cycles, readings_due.size());
      $display("tb_pec_checked_readback_unpacker_core NOT OK");
      $finish;
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    mismatch_count++;
    $display("MISMATCH result %0d %s: got %0h expected %0h", results_seen, what, got, want);
  endtask

  // Data bytes that precede the PEC byte in each group
  function automatic logic [BCNT_W-1:0] data_len(input grp_t g);
    case (g)
      GRP_CELLS: return 5'd18;
      GRP_TEMPS: return 5'd5;
      GRP_FLAGS: return 5'd3;
      default:   return 5'd2;
    endcase
  endfunction

  // CRC-8, polynomial x^8 + x^2 + x + 1, fed one bit at a time from the MSB.
  function automatic logic [7:0] pec_after(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c = {c[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
    end
    return c;
  endfunction

  // Offset-binary reading to signed value; division truncates toward zero.
  function automatic logic [VALUE_W-1:0] scaled(input logic [11:0] raw);
    int d;
    int v;
    d = int'(raw) - 512;
    v = (d * 3) / 2;
    return v[VALUE_W-1:0];
  endfunction

  function automatic reading_t reading(input logic [VIDX_W-1:0] vidx,
                                       input logic [VALUE_W-1:0] value,
                                       input logic [MASK_W-1:0] under,
                                       input logic [MASK_W-1:0] over,
                                       input logic status);
    reading_t r;
    r.mod = modules_done;
    r.vidx = vidx;
    r.value = value;
    r.under = under;
    r.over = over;
    r.status = status;
    r.last = 1'b0;
    r.fend = 1'b0;
    return r;
  endfunction

  // Works out the readings caused by one accepted beat and leaves them in new_readings.
  task automatic decode_readback_byte(input logic start, input grp_t g, input logic [7:0] b);
    logic [MASK_W-1:0] um;
    logic [MASK_W-1:0] om;
    logic              final_mod;
    new_readings.delete();
    if (start) begin
      frame_armed = 1'b1;
      grp_held = g;
      bytes_in = '0;
      modules_done = '0;
      pec_now = CRC_START;
      return;
    end
    if (!frame_armed) return;

    // Data byte: buffer it and fold it into the PEC.
    if (bytes_in < data_len(grp_held)) begin
      chain_bytes[bytes_in] = b;
      pec_now = pec_after(pec_now, b);
      bytes_in = bytes_in + 5'd1;
      return;
    end

    // PEC byte that does not match aborts the frame.
    if (b != pec_now) begin
      new_readings.push_back(reading(4'd0, '0, '0, '0, 1'b1));
      new_readings[0].last = 1'b1;
      new_readings[0].fend = 1'b1;
      frame_armed = 1'b0;
      return;
    end

    case (grp_held)
      GRP_CELLS: begin
        for (int k = 0; k < 6; k++) begin
          new_readings.push_back(reading(4'(2 * k),
            scaled({chain_bytes[3*k+1][3:0], chain_bytes[3*k]}), '0, '0, 1'b0));
          new_readings.push_back(reading(4'(2 * k + 1),
            scaled({chain_bytes[3*k+2], chain_bytes[3*k+1][7:4]}), '0, '0, 1'b0));
        end
      end
      GRP_TEMPS: begin
        new_readings.push_back(reading(4'd0,
          scaled({chain_bytes[1][3:0], chain_bytes[0]}), '0, '0, 1'b0));
        new_readings.push_back(reading(4'd1,
          scaled({chain_bytes[2], chain_bytes[1][7:4]}), '0, '0, 1'b0));
        new_readings.push_back(reading(4'd2,
          scaled({chain_bytes[4][3:0], chain_bytes[3]}), '0, '0, 1'b0));
      end
      GRP_FLAGS: begin
        // Even bits flag under-voltage, odd bits over-voltage, four cells per byte.
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 4; j++) begin
            um[4*i+j] = chain_bytes[i][2*j];
            om[4*i+j] = chain_bytes[i][2*j+1];
          end
        end
        new_readings.push_back(reading(4'd0, '0, um, om, 1'b0));
      end
      default: begin
        new_readings.push_back(reading(4'd0,
          scaled({chain_bytes[1][3:0], chain_bytes[0]}), '0, '0, 1'b0));
      end
    endcase

    final_mod = (int'(modules_done) + 1 >= CHAIN_MODULES);
    new_readings[new_readings.size()-1].last = 1'b1;
    new_readings[new_readings.size()-1].fend = final_mod;
    modules_done = modules_done + 4'd1;
    bytes_in = '0;
    pec_now = CRC_START;
    if (final_mod) frame_armed = 1'b0;
  endtask

  // Drives one beat, waits for it to be taken and books the readings it causes.
  task automatic send_beat(input logic start, input grp_t g, input logic [7:0] b,
                           input logic typed, input reading_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= {g, start};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_readback_byte(start, g, b);
    if (typed) begin
      readings_due.push_back(want);
    end else begin
      foreach (new_readings[i]) readings_due.push_back(new_readings[i]);
    end
  endtask

  // Holds the sender off until every booked reading has come out.
  task automatic drain_readings();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (readings_due.size() != 0);
  endtask

  task automatic set_phase(input int p);
    case (p)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 68; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 68; end
      default: begin sender_idle_pct = 13; receiver_stall_pct = 13; end
    endcase
  endtask

  function automatic logic [7:0] any_byte();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 8'h00;
    if (pick < 20) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic row_t beat(input logic start, input grp_t g, input logic [7:0] b,
                                input pec_t pec, input logic typed,
                                input logic [MOD_W-1:0] mi, input logic [VALUE_W-1:0] v,
                                input logic status, input logic fend);
    row_t r;
    r.start = start;
    r.grp = g;
    r.rx = b;
    r.pec = pec;
    r.typed = typed;
    r.want = '{mod: mi, vidx: '0, value: v, under: '0, over: '0,
               status: status, last: 1'b1, fend: fend};
    return r;
  endfunction

  // Result monitor: every taken beat is held against the oldest booked reading.
  always @(posedge clk) begin : result_check
    reading_t got;
    reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got.mod    = out_tdata[3:0];
      got.vidx   = out_tdata[7:4];
      got.value  = out_tdata[21:8];
      got.under  = out_tdata[33:22];
      got.over   = out_tdata[45:34];
      got.status = out_tuser[0];
      got.fend   = out_tuser[1];
      got.last   = out_tlast;
      if (out_tdata[47:46] !== 2'b00) flag_mismatch("pad bits", 16'(out_tdata[47:46]), 16'd0);
      if (readings_due.size() == 0) begin
        flag_mismatch("unbooked result, module", 16'(got.mod), 16'hFFFF);
      end else begin
        want = readings_due.pop_front();
        if (got.mod !== want.mod) flag_mismatch("module_index", 16'(got.mod), 16'(want.mod));
        if (got.vidx !== want.vidx) flag_mismatch("value_index", 16'(got.vidx), 16'(want.vidx));
        if (got.value !== want.value) flag_mismatch("value", 16'(got.value), 16'(want.value));
        if (got.under !== want.under) flag_mismatch("under_mask", 16'(got.under), 16'(want.under));
        if (got.over !== want.over) flag_mismatch("over_mask", 16'(got.over), 16'(want.over));
        if (got.status !== want.status) begin
          flag_mismatch("status", 16'(got.status), 16'(want.status));
        end
        if (got.last !== want.last) flag_mismatch("last", 16'(got.last), 16'(want.last));
        if (got.fend !== want.fend) flag_mismatch("frame_end", 16'(got.fend), 16'(want.fend));
      end
    end
  end

  initial begin : stimulus
    row_t       dir_rows[$];
    row_t       r;
    reading_t   none;
    logic [7:0] b;
    grp_t       g;
    int         sent;
    int         frames;
    int         n;
    logic       dropped;

    none = '0;
    frame_armed = 1'b0;
    grp_held = GRP_CELLS;
    bytes_in = '0;
    modules_done = '0;
    pec_now = CRC_START;

    // Directed table: typed readings are the extremes, the truncation case and a PEC error.
    dir_rows = '{
      beat(1'b0, GRP_CELLS, 8'h5A, PEC_NONE, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b1, GRP_REF,   8'hFF, PEC_NONE, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b0, GRP_REF,   8'h00, PEC_NONE, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b0, GRP_REF,   8'h00, PEC_NONE, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b0, GRP_REF,   8'h00, PEC_GOOD, 1'b1, 4'd0, -14'sd768, 1'b0, 1'b0),
      beat(1'b0, GRP_REF,   8'hFF, PEC_NONE, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b0, GRP_REF,   8'hFF, PEC_NONE, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b0, GRP_REF,   8'h00, PEC_GOOD, 1'b1, 4'd1, 14'sd5374, 1'b0, 1'b1),
      beat(1'b0, GRP_TEMPS, 8'hA5, PEC_NONE, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b1, GRP_FLAGS, 8'h00, PEC_NONE, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b0, GRP_FLAGS, 8'hFF, PEC_NONE, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b0, GRP_FLAGS, 8'h55, PEC_NONE, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b0, GRP_FLAGS, 8'hAA, PEC_NONE, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b0, GRP_FLAGS, 8'h00, PEC_GOOD, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b1, GRP_TEMPS, 8'h3C, PEC_NONE, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b0, GRP_TEMPS, 8'h00, PEC_NONE, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b0, GRP_TEMPS, 8'hF0, PEC_NONE, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b0, GRP_TEMPS, 8'hFF, PEC_NONE, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b0, GRP_TEMPS, 8'h34, PEC_NONE, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b0, GRP_TEMPS, 8'h12, PEC_NONE, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b0, GRP_TEMPS, 8'h00, PEC_GOOD, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b1, GRP_REF,   8'h00, PEC_NONE, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b0, GRP_REF,   8'hFF, PEC_NONE, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b0, GRP_REF,   8'h01, PEC_NONE, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b0, GRP_REF,   8'h00, PEC_GOOD, 1'b1, 4'd0, -14'sd1, 1'b0, 1'b0),
      beat(1'b0, GRP_REF,   8'h01, PEC_NONE, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b0, GRP_REF,   8'h00, PEC_NONE, 1'b0, 4'd0, '0, 1'b0, 1'b0),
      beat(1'b0, GRP_REF,   8'h00, PEC_BAD,  1'b1, 4'd1, 14'sd0, 1'b1, 1'b1)
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part; the PEC byte is taken from the predictor so it lands right or wrong.
    set_phase(3);
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      case (r.pec)
        PEC_GOOD: b = pec_now;
        PEC_BAD:  b = pec_now ^ 8'hFF;
        default:  b = r.rx;
      endcase
      send_beat(r.start, r.grp, b, r.typed, r.want);
    end
    drain_readings();

    // Random frames: mostly well-formed, with stray bytes, dropped frames and bad PECs.
    sent = 0;
    frames = 0;
    while (sent < RANDOM_BEATS) begin
      set_phase((sent / 40) % 4);
      if ($urandom_range(99) < 6) begin
        send_beat(1'($urandom_range(1)), grp_t'($urandom_range(3)), any_byte(), 1'b0, none);
        continue;
      end
      g = grp_t'($urandom_range(3));
      send_beat(1'b1, g, any_byte(), 1'b0, none);
      sent++;
      for (int m = 0; m < CHAIN_MODULES; m++) begin
        n = int'(data_len(g));
        dropped = 1'b0;
        for (int k = 0; k < n; k++) begin
          // A new start may cut this module short.
          if ($urandom_range(99) < 2) begin
            dropped = 1'b1;
            break;
          end
          send_beat(1'b0, grp_t'($urandom_range(3)), any_byte(), 1'b0, none);
          sent++;
        end
        if (dropped) break;
        if ($urandom_range(99) < 12) begin
          send_beat(1'b0, g, pec_now ^ 8'($urandom_range(255, 1)), 1'b0, none);
          sent++;
          break;
        end
        send_beat(1'b0, g, pec_now, 1'b0, none);
        sent++;
      end
      frames++;
      if (frames == 3 || $urandom_range(99) < 8) drain_readings();
    end

    // Wind down: let every booked reading arrive, then watch for strays.
    in_tvalid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_pec_checked_readback_unpacker_core OK");
    end else begin
      $display("tb_pec_checked_readback_unpacker_core NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pcru_pkg.sv
hdl/pcru_front.sv
hdl/pcru_queue.sv
hdl/pcru_back.sv
hdl/pec_checked_readback_unpacker_core.sv
dv/tb_pec_checked_readback_unpacker_core.sv
